// ===== sv/cei_pkg.sv =====
// Shared widths, constants and types of the coulomb and energy integrator.
package cei_pkg;

   localparam int CURRENT_BITS = 16;
   localparam int POWER_BITS   = 24;
   localparam int ACC_BITS     = 64;
   localparam int TIME_BITS    = 32;

   localparam int DIR_BITS   = ACC_BITS - 1;
   localparam int VAL_BITS   = (CURRENT_BITS > POWER_BITS) ? CURRENT_BITS : POWER_BITS;
   localparam int SUM_BITS   = VAL_BITS + 1;
   localparam int MAG_BITS   = VAL_BITS + 1;
   localparam int P_BITS     = VAL_BITS - 1;
   localparam int P2_BITS    = 2 * P_BITS;
   localparam int SQ_BITS    = 2 * TIME_BITS;
   localparam int NUM_BITS   = P2_BITS + TIME_BITS + 1;
   localparam int QUO_BITS   = P_BITS + TIME_BITS;
   localparam int SM_BITS    = MAG_BITS + TIME_BITS;
   localparam int NEG_BITS   = SM_BITS + 1;
   localparam int MUL_A_BITS = (MAG_BITS > TIME_BITS) ? MAG_BITS : TIME_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + TIME_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

   localparam int REQ_FIELD_BITS = TIME_BITS + CURRENT_BITS + POWER_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_FIELD_BITS = 2 * ACC_BITS + 4 * DIR_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int REQ_TIME_LSB = 0;
   localparam int REQ_CUR_LSB  = TIME_BITS;
   localparam int REQ_PWR_LSB  = TIME_BITS + CURRENT_BITS;

   localparam int TUSER_FUNC  = 0;
   localparam int TUSER_VALID = 1;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_MAX_GAP = '0;

   localparam logic [TIME_BITS-1:0] GAP_RESET = TIME_BITS'(5000);

   localparam logic [1:0] DIR_OUT_CHARGE = 2'd0;
   localparam logic [1:0] DIR_IN_CHARGE  = 2'd1;
   localparam logic [1:0] DIR_OUT_ENERGY = 2'd2;
   localparam logic [1:0] DIR_IN_ENERGY  = 2'd3;

   typedef struct packed {
      logic                done;
      logic [NUM_BITS-1:0] quo;
   } div_res_type;

endpackage

// ===== sv/cei_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module cei_div
   import cei_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                div_start,
   input  logic [NUM_BITS-1:0] div_num,
   input  logic [VAL_BITS-1:0] div_den,
   output div_res_type         div_res
);

   logic [VAL_BITS-1:0]     rem_ff;
   logic [VAL_BITS-1:0]     den_ff;
   logic [NUM_BITS-1:0]     quo_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   logic [VAL_BITS:0]   trial;
   logic                ge_in;
   logic [VAL_BITS-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_BITS-1]};
      ge_in  = trial >= {1'b0, den_ff};
      rem_in = ge_in ? VAL_BITS'(trial - {1'b0, den_ff}) : VAL_BITS'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            rem_ff  <= '0;
            den_ff  <= div_den;
            quo_ff  <= div_num;
            cnt_ff  <= DIV_CNT_BITS'(NUM_BITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[NUM_BITS-2:0], ge_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_res.done = done_ff;
   assign div_res.quo  = quo_ff;

endmodule

// ===== sv/coulomb_energy_integrator.sv =====
// Top level of the trapezoidal coulomb and energy integrator.
// Each request transaction carries a timestamp, a signed current and a signed power, with a
// sample-valid flag and a clear command in tuser; each one returns exactly one response
// transaction with the net and direction-split totals after it, in units of 0.5 mA*ms and
// 0.5 mW*ms, and a tuser flag that is set when an interval was added. The block handles one
// request at a time and deasserts req_tready while it works. A clear, an invalid sample or a
// sample that only re-bases the origin passes through the check and done states before its
// response is registered. An integrated sample adds, per channel (charge, then energy), the
// prep, multiply and net states when the segment keeps its sign, through the shared 32x32
// multiplier. A segment that crosses zero is split with a restoring divider that resolves
// one bit per cycle over a 79-bit dividend. A response that is not taken yet holds the next
// one back in its final state.
module coulomb_energy_integrator
   import cei_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // time_ms[31:0], current_ma[47:32], power_mw[71:48]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // func[0], sample_valid[1]
   input  logic [REQ_TUSER_BITS-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // net_charge[63:0], net_energy[127:64], out_charge[190:128], in_charge[253:191],
   // out_energy[316:254], in_energy[379:317], zero fill above
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // integrated[0]
   output logic                      rsp_tuser,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_PREP, ST_MSM, ST_NET, ST_MSQ, ST_SQ, ST_MLO, ST_MHI,
      ST_NUM, ST_DSTART, ST_DWAIT, ST_POS, ST_NEG, ST_DONE
   } state_type;

   typedef enum logic [1:0] {KIND_OUT, KIND_IN, KIND_SPLIT} kind_type;

   localparam logic signed [ACC_BITS-1:0] NET_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] NET_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic [DIR_BITS-1:0] DIR_MAX = '1;
   localparam int NET_W = ((ACC_BITS > SM_BITS) ? ACC_BITS : SM_BITS) + 2;
   localparam int DIR_W = ((DIR_BITS > NEG_BITS) ? DIR_BITS : NEG_BITS) + 1;

   function automatic logic signed [ACC_BITS-1:0] net_sat(
      input logic signed [ACC_BITS-1:0] acc,
      input logic                       neg,
      input logic [SM_BITS-1:0]         m
   );
      logic signed [NET_W-1:0] ext_m;
      logic signed [NET_W-1:0] total;
      ext_m = signed'(NET_W'(m));
      if (neg) begin
         ext_m = -ext_m;
      end
      total = NET_W'(acc) + ext_m;
      if (total > NET_W'(NET_MAX)) begin
         return NET_MAX;
      end else if (total < NET_W'(NET_MIN)) begin
         return NET_MIN;
      end
      return ACC_BITS'(total);
   endfunction

   function automatic logic [DIR_BITS-1:0] dir_sat(
      input logic [DIR_BITS-1:0] acc,
      input logic [NEG_BITS-1:0] m
   );
      logic [DIR_W-1:0] total;
      total = DIR_W'(acc) + DIR_W'(m);
      if (total > DIR_W'(DIR_MAX)) begin
         return DIR_MAX;
      end
      return DIR_BITS'(total);
   endfunction

   state_type state_ff;
   kind_type  kind_ff;

   logic [TIME_BITS-1:0]           max_gap_ff;
   logic                           func_ff;
   logic                           svalid_ff;
   logic [TIME_BITS-1:0]           time_ff;
   logic signed [CURRENT_BITS-1:0] cur_ff;
   logic signed [POWER_BITS-1:0]   pwr_ff;
   logic                           have_origin_ff;
   logic [TIME_BITS-1:0]           org_time_ff;
   logic signed [CURRENT_BITS-1:0] org_cur_ff;
   logic signed [POWER_BITS-1:0]   org_pwr_ff;
   logic                           upd_origin_ff;
   logic                           integ_ff;
   logic                           chan_ff;
   logic [TIME_BITS-1:0]           dt_ff;
   logic                           sneg_ff;
   logic [MAG_BITS-1:0]            smag_ff;
   logic [P_BITS-1:0]              p_ff;
   logic [VAL_BITS-1:0]            d_ff;
   logic [PROD_BITS-1:0]           prod_ff;
   logic [SM_BITS-1:0]             sm_ff;
   logic [SQ_BITS-1:0]             sq_ff;
   logic [NUM_BITS-1:0]            num_ff;
   logic [NEG_BITS-1:0]            neg_ff;
   logic signed [ACC_BITS-1:0]     net_ff [2];
   logic [DIR_BITS-1:0]            dir_ff [4];
   logic                           rsp_tvalid_ff;
   logic [RSP_TDATA_BITS-1:0]      rsp_tdata_ff;
   logic                           rsp_tuser_ff;

   logic signed [VAL_BITS-1:0] val_a;
   logic signed [VAL_BITS-1:0] val_b;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] diff_in;
   logic [TIME_BITS-1:0]       dt_in;
   logic [MUL_A_BITS-1:0]      mul_a;
   logic [TIME_BITS-1:0]       mul_b;
   logic [PROD_BITS-1:0]       prod_in;
   logic [QUO_BITS-1:0]        pos_in;
   logic [1:0]                 dir_idx;
   logic [NEG_BITS-1:0]        dir_m;
   logic [DIR_BITS-1:0]        dir_sat_in;
   logic signed [ACC_BITS-1:0] net_sat_in;
   logic                       csr_wr;
   logic                       div_start;
   div_res_type                div_res;

   cei_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (num_ff),
      .div_den   (d_ff),
      .div_res   (div_res)
   );

   assign div_start = (state_ff == ST_DSTART);
   assign pos_in    = div_res.quo[QUO_BITS-1:0];

   always_comb begin
      val_a   = chan_ff ? VAL_BITS'(org_pwr_ff) : VAL_BITS'(org_cur_ff);
      val_b   = chan_ff ? VAL_BITS'(pwr_ff) : VAL_BITS'(cur_ff);
      sum_in  = SUM_BITS'(val_a) + SUM_BITS'(val_b);
      diff_in = SUM_BITS'(val_a) - SUM_BITS'(val_b);
      dt_in   = time_ff - org_time_ff;
   end

   always_comb begin
      case (state_ff)
         ST_MSM: begin
            mul_a = MUL_A_BITS'(smag_ff);
            mul_b = dt_ff;
         end
         ST_MSQ: begin
            mul_a = MUL_A_BITS'(p_ff);
            mul_b = TIME_BITS'(p_ff);
         end
         ST_MLO: begin
            mul_a = MUL_A_BITS'(sq_ff[TIME_BITS-1:0]);
            mul_b = dt_ff;
         end
         ST_MHI: begin
            mul_a = MUL_A_BITS'(sq_ff[SQ_BITS-1:TIME_BITS]);
            mul_b = dt_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   always_comb begin
      case (state_ff)
         ST_NET: begin
            dir_idx = {chan_ff, kind_ff == KIND_IN};
            dir_m   = NEG_BITS'(prod_ff[SM_BITS-1:0]);
         end
         ST_POS: begin
            dir_idx = {chan_ff, 1'b0};
            dir_m   = NEG_BITS'(pos_in);
         end
         ST_NEG: begin
            dir_idx = {chan_ff, 1'b1};
            dir_m   = neg_ff;
         end
         default: begin
            dir_idx = {chan_ff, 1'b0};
            dir_m   = '0;
         end
      endcase
      dir_sat_in = dir_sat(dir_ff[dir_idx], dir_m);
      net_sat_in = net_sat(net_ff[chan_ff], sneg_ff, prod_ff[SM_BITS-1:0]);
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_MAX_GAP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_gap_ff     <= GAP_RESET;
         have_origin_ff <= 1'b0;
         org_time_ff    <= '0;
         org_cur_ff     <= '0;
         org_pwr_ff     <= '0;
         rsp_tvalid_ff  <= 1'b0;
         chan_ff        <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            net_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            dir_ff[i] <= '0;
         end
      end else begin
         if (csr_wr) begin
            max_gap_ff <= csr_pwdata[TIME_BITS-1:0];
         end
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff   <= req_tuser[TUSER_FUNC];
                  svalid_ff <= req_tuser[TUSER_VALID];
                  time_ff   <= req_tdata[REQ_TIME_LSB +: TIME_BITS];
                  cur_ff    <= req_tdata[REQ_CUR_LSB +: CURRENT_BITS];
                  pwr_ff    <= req_tdata[REQ_PWR_LSB +: POWER_BITS];
                  state_ff  <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               integ_ff      <= 1'b0;
               upd_origin_ff <= 1'b0;
               chan_ff       <= 1'b0;
               dt_ff         <= dt_in;
               if (func_ff == FUNC_CLEAR) begin
                  have_origin_ff <= 1'b0;
                  for (int i = 0; i < 2; i++) begin
                     net_ff[i] <= '0;
                  end
                  for (int i = 0; i < 4; i++) begin
                     dir_ff[i] <= '0;
                  end
                  state_ff <= ST_DONE;
               end else if (!svalid_ff) begin
                  have_origin_ff <= 1'b0;
                  state_ff       <= ST_DONE;
               end else begin
                  upd_origin_ff <= 1'b1;
                  if (have_origin_ff && (dt_in != '0) && (dt_in <= max_gap_ff)) begin
                     integ_ff <= 1'b1;
                     state_ff <= ST_PREP;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_PREP: begin
               sneg_ff <= sum_in < 0;
               smag_ff <= (sum_in < 0) ? MAG_BITS'(-sum_in) : MAG_BITS'(sum_in);
               if (val_a >= 0 && val_b >= 0) begin
                  kind_ff <= KIND_OUT;
               end else if (val_a <= 0 && val_b <= 0) begin
                  kind_ff <= KIND_IN;
               end else begin
                  kind_ff <= KIND_SPLIT;
               end
               if (val_a > 0) begin
                  p_ff <= P_BITS'(val_a);
                  d_ff <= VAL_BITS'(diff_in);
               end else begin
                  p_ff <= P_BITS'(val_b);
                  d_ff <= VAL_BITS'(-diff_in);
               end
               state_ff <= ST_MSM;
            end
            ST_MSM: begin
               prod_ff  <= prod_in;
               state_ff <= ST_NET;
            end
            ST_NET: begin
               net_ff[chan_ff] <= net_sat_in;
               sm_ff           <= prod_ff[SM_BITS-1:0];
               case (kind_ff)
                  KIND_OUT, KIND_IN: begin
                     dir_ff[dir_idx] <= dir_sat_in;
                     if (!chan_ff) begin
                        chan_ff  <= 1'b1;
                        state_ff <= ST_PREP;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
                  default: begin
                     state_ff <= ST_MSQ;
                  end
               endcase
            end
            ST_MSQ: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               sq_ff    <= prod_ff[SQ_BITS-1:0];
               state_ff <= ST_MLO;
            end
            ST_MLO: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MHI;
            end
            ST_MHI: begin
               num_ff   <= NUM_BITS'(prod_ff) + NUM_BITS'(d_ff >> 1);
               prod_ff  <= prod_in;
               state_ff <= ST_NUM;
            end
            ST_NUM: begin
               num_ff   <= num_ff + (NUM_BITS'(prod_ff) << TIME_BITS);
               state_ff <= ST_DSTART;
            end
            ST_DSTART: begin
               state_ff <= ST_DWAIT;
            end
            ST_DWAIT: begin
               if (div_res.done) begin
                  state_ff <= ST_POS;
               end
            end
            ST_POS: begin
               dir_ff[dir_idx] <= dir_sat_in;
               if (sneg_ff) begin
                  neg_ff <= NEG_BITS'(pos_in) + NEG_BITS'(sm_ff);
               end else begin
                  neg_ff <= NEG_BITS'(pos_in) - NEG_BITS'(sm_ff);
               end
               state_ff <= ST_NEG;
            end
            ST_NEG: begin
               dir_ff[dir_idx] <= dir_sat_in;
               if (!chan_ff) begin
                  chan_ff  <= 1'b1;
                  state_ff <= ST_PREP;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= integ_ff;
                  rsp_tdata_ff  <= RSP_TDATA_BITS'({dir_ff[DIR_IN_ENERGY],
                                                    dir_ff[DIR_OUT_ENERGY],
                                                    dir_ff[DIR_IN_CHARGE],
                                                    dir_ff[DIR_OUT_CHARGE],
                                                    net_ff[1], net_ff[0]});
                  if (upd_origin_ff) begin
                     have_origin_ff <= 1'b1;
                     org_time_ff    <= time_ff;
                     org_cur_ff     <= cur_ff;
                     org_pwr_ff     <= pwr_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_MAX_GAP) ?
                       CSR_DATA_BITS'(max_gap_ff) : '0;

endmodule

// ===== sv/cei_checker.sv =====
// Port-level checker of the coulomb and energy integrator and its bind statement.
module cei_checker
   import cei_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_TDATA_BITS-1:0] req_tdata,
   input logic [REQ_TUSER_BITS-1:0] req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                      csr_pready
);

   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in progress");

   // A new response is produced only from the busy phase.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a transaction in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // A gap register write is visible to the next read.
   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_MAX_GAP)
      |=> (!(csr_psel && !csr_pwrite && csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_MAX_GAP) ||
           csr_prdata == $past(csr_pwdata)))
      else $error("gap register read back differs from the last write");

endmodule

bind coulomb_energy_integrator cei_checker u_cei_checker (.*);

// ===== tb/tb_coulomb_energy_integrator.sv =====
// Self-checking testbench for the coulomb and energy integrator, with a trapezoid predictor.
`timescale 1ns / 1ps

module tb_coulomb_energy_integrator;
   import cei_pkg::*;

   localparam int CHARGE = 0;
   localparam int ENERGY = 1;
   localparam longint NET_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint NET_MIN = -NET_MAX - 1;
   localparam logic [63:0] DIR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [CSR_ADDR_BITS-1:0] GAP_ADDR   = {CSR_IDX_MAX_GAP, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~CSR_IDX_MAX_GAP, 2'b00};

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_EVERY4, RDY_MOSTLY} ready_mode_e;

   typedef struct {
      logic                    func;
      logic                    smp_valid;
      logic [31:0]             time_ms;
      logic signed [CURRENT_BITS-1:0] current_ma;
      logic signed [POWER_BITS-1:0]   power_mw;
   } sample_t;

   typedef struct {
      logic [63:0] net_charge;
      logic [63:0] net_energy;
      logic [63:0] out_charge;
      logic [63:0] in_charge;
      logic [63:0] out_energy;
      logic [63:0] in_energy;
      logic        integrated;
   } totals_t;

   class totals_tracker;
      logic [31:0] max_gap;
      bit          have_origin;
      logic [31:0] origin_time;
      longint      origin_current;
      longint      origin_power;
      longint      net_total[2];
      logic [63:0] dir_total[4];
      totals_t     expected_totals[$];
      int          errors;

      function new();
         max_gap = GAP_RESET;
         errors = 0;
         clear_totals();
      endfunction

      function void clear_totals();
         have_origin = 0;
         origin_time = '0;
         origin_current = 0;
         origin_power = 0;
         net_total[CHARGE] = 0;
         net_total[ENERGY] = 0;
         foreach (dir_total[i]) dir_total[i] = '0;
      endfunction

      function void write_register(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] value);
         if (addr[CSR_ADDR_BITS-1:2] == CSR_IDX_MAX_GAP) max_gap = value;
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction

      function void add_direction(int idx, logic [63:0] amount);
         logic [64:0] sum;
         sum = {1'b0, dir_total[idx]} + {1'b0, amount};
         dir_total[idx] = (sum > {1'b0, DIR_MAX}) ? DIR_MAX : sum[63:0];
      endfunction

      function void add_segment(int chan, longint a, longint b, logic [31:0] dt);
         longint s;
         logic [63:0] mag_s, area, p, d, pos, neg;
         logic [127:0] num;
         logic signed [65:0] wide, delta;
         int out_i, in_i;
         s = a + b;
         mag_s = (s < 0) ? -s : s;
         area = mag_s * {32'd0, dt};
         delta = $signed({2'b00, area});
         if (s < 0) delta = -delta;
         wide = net_total[chan];
         wide = wide + delta;
         if (wide > NET_MAX) net_total[chan] = NET_MAX;
         else if (wide < NET_MIN) net_total[chan] = NET_MIN;
         else net_total[chan] = wide[63:0];
         out_i = (chan == ENERGY) ? DIR_OUT_ENERGY : DIR_OUT_CHARGE;
         in_i  = (chan == ENERGY) ? DIR_IN_ENERGY : DIR_IN_CHARGE;
         if (a >= 0 && b >= 0) begin
            add_direction(out_i, area);
         end else if (a <= 0 && b <= 0) begin
            add_direction(in_i, area);
         end else begin
            // The segment crosses zero: the positive share is the triangle up to the crossing.
            p = (a > 0) ? a : b;
            d = (a > b) ? a - b : b - a;
            num = {64'd0, p} * {64'd0, p} * {96'd0, dt} + {64'd0, d >> 1};
            num = num / {64'd0, d};
            pos = num[63:0];
            neg = (s >= 0) ? pos - area : pos + area;
            add_direction(out_i, pos);
            add_direction(in_i, neg);
         end
      endfunction

      function void note_sample(sample_t smp);
         totals_t expv;
         logic [31:0] dt;
         bit done;
         done = 0;
         if (smp.func == FUNC_CLEAR) begin
            clear_totals();
         end else if (!smp.smp_valid) begin
            have_origin = 0;
         end else begin
            dt = smp.time_ms - origin_time;
            if (have_origin && dt != 0 && dt <= max_gap) begin
               add_segment(CHARGE, origin_current, smp.current_ma, dt);
               add_segment(ENERGY, origin_power, smp.power_mw, dt);
               done = 1;
            end
            have_origin = 1;
            origin_time = smp.time_ms;
            origin_current = smp.current_ma;
            origin_power = smp.power_mw;
         end
         expv.net_charge = net_total[CHARGE];
         expv.net_energy = net_total[ENERGY];
         expv.out_charge = dir_total[DIR_OUT_CHARGE];
         expv.in_charge  = dir_total[DIR_IN_CHARGE];
         expv.out_energy = dir_total[DIR_OUT_ENERGY];
         expv.in_energy  = dir_total[DIR_IN_ENERGY];
         expv.integrated = done;
         expected_totals.push_back(expv);
      endfunction

      function void compare_field(string name, logic [63:0] expv, logic [63:0] actual);
         if (actual !== expv) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actual);
            errors++;
         end
      endfunction

      function void check_totals(logic [RSP_TDATA_BITS-1:0] data, logic flag);
         totals_t expv;
         if (expected_totals.size() == 0) begin
            $display("%0t: response transaction with nothing expected, data %h", $time, data);
            errors++;
            return;
         end
         expv = expected_totals.pop_front();
         compare_field("net_charge", expv.net_charge, data[0 +: ACC_BITS]);
         compare_field("net_energy", expv.net_energy, data[ACC_BITS +: ACC_BITS]);
         compare_field("out_charge", expv.out_charge, data[2*ACC_BITS +: DIR_BITS]);
         compare_field("in_charge", expv.in_charge, data[2*ACC_BITS + DIR_BITS +: DIR_BITS]);
         compare_field("out_energy", expv.out_energy,
                       data[2*ACC_BITS + 2*DIR_BITS +: DIR_BITS]);
         compare_field("in_energy", expv.in_energy, data[2*ACC_BITS + 3*DIR_BITS +: DIR_BITS]);
         compare_field("integrated", expv.integrated, flag);
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   totals_tracker tracker = new();
   int burst_left = 1;

   coulomb_energy_integrator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("coulomb_energy_integrator test failed");
      $finish;
   end

   function automatic sample_t make_sample(logic f, logic v, logic [31:0] t,
                                           logic signed [CURRENT_BITS-1:0] c,
                                           logic signed [POWER_BITS-1:0] p);
      sample_t smp;
      smp.func = f;
      smp.smp_valid = v;
      smp.time_ms = t;
      smp.current_ma = c;
      smp.power_mw = p;
      return smp;
   endfunction

   function automatic logic [31:0] random_level(int bits);
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return $urandom_range(0, 8) - 4;
         default: begin
            case ($urandom_range(0, 3))
               0: return (32'd1 << (bits - 1)) - 1;
               1: return 32'd1 << (bits - 1);
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic sample_t random_sample(inout logic [31:0] now, input logic [31:0] gap);
      sample_t smp;
      int pick;
      logic [31:0] dt;
      pick = $urandom_range(0, 99);
      smp.func = FUNC_SAMPLE;
      smp.smp_valid = 1'b1;
      if (pick < 4) begin
         smp.func = FUNC_CLEAR;
         smp.smp_valid = $urandom_range(0, 1);
      end else if (pick < 9) begin
         smp.smp_valid = 1'b0;
      end
      if (pick < 12) dt = '0;
      else if (pick < 16) dt = (gap < 32'hFFFF_0000) ? gap + 1 + $urandom_range(0, 1000) : '0;
      else if (pick < 19) dt = gap;
      else if (pick < 24 && gap != 0) dt = $urandom_range(1, gap);
      else dt = $urandom_range(1, (gap > 2000 || gap == 0) ? 2000 : gap);
      now = now + dt;
      smp.time_ms = now;
      smp.current_ma = random_level(CURRENT_BITS);
      smp.power_mw = random_level(POWER_BITS);
      return smp;
   endfunction

   task automatic send_sample(sample_t smp);
      logic [REQ_TDATA_BITS-1:0] data;
      logic [REQ_TUSER_BITS-1:0] user;
      int gap_len;
      data = '0;
      data[REQ_TIME_LSB +: TIME_BITS] = smp.time_ms;
      data[REQ_CUR_LSB +: CURRENT_BITS] = smp.current_ma;
      data[REQ_PWR_LSB +: POWER_BITS] = smp.power_mw;
      user = '0;
      user[TUSER_FUNC] = smp.func;
      user[TUSER_VALID] = smp.smp_valid;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= user;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(smp);
      burst_left--;
      if (burst_left <= 0) begin
         gap_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap_len - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_register(addr, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check_gap();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= GAP_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tracker.max_gap) begin
         $display("%0t: max_gap_ms readback mismatch, expected %h, actual %h",
                  $time, tracker.max_gap, csr_prdata);
         tracker.errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_gap(logic [31:0] value);
      drain();
      csr_write(GAP_ADDR, value);
      csr_check_gap();
   endtask

   // The receiver changes its stall pattern now and then, and twice holds off for a long
   // stretch so that the block backs up into its request side.
   initial begin
      ready_mode_e mode;
      int mode_left, phase, seen, hold_left;
      mode = RDY_ALWAYS;
      mode_left = 0;
      phase = 0;
      seen = 0;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_e'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
               RDY_ALWAYS: rsp_tready <= 1'b1;
               RDY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
               RDY_EVERY4: rsp_tready <= (phase % 4 == 0);
               default:    rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_totals(rsp_tdata, rsp_tuser);
            seen++;
            if (seen == 100 || seen == 450) hold_left = $urandom_range(200, 400);
         end
      end
   end

   initial begin
      logic [31:0] now;
      logic [31:0] gap_plan[$];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_check_gap();

      send_sample(make_sample(FUNC_SAMPLE, 1, 1000, 0, 0));
      send_sample(make_sample(FUNC_SAMPLE, 1, 1000, 5, 5));
      send_sample(make_sample(FUNC_SAMPLE, 1, 1001, 32767, 8388607));
      send_sample(make_sample(FUNC_SAMPLE, 1, 1101, -32768, -8388608));
      send_sample(make_sample(FUNC_SAMPLE, 1, 1201, -1, -1));
      send_sample(make_sample(FUNC_SAMPLE, 1, 1202, 1, 1));
      send_sample(make_sample(FUNC_SAMPLE, 1, 6202, 300, -200));
      send_sample(make_sample(FUNC_SAMPLE, 1, 11203, -5, 7));
      send_sample(make_sample(FUNC_SAMPLE, 0, 11204, 100, 100));
      send_sample(make_sample(FUNC_SAMPLE, 1, 11300, 7, -9));
      send_sample(make_sample(FUNC_SAMPLE, 1, 11303, 0, 0));
      send_sample(make_sample(FUNC_SAMPLE, 1, 11310, -7, 3));
      send_sample(make_sample(FUNC_CLEAR, 0, 0, 0, 0));
      send_sample(make_sample(FUNC_SAMPLE, 1, 32'hFFFF_FFF0, -32768, 8388607));
      send_sample(make_sample(FUNC_SAMPLE, 1, 32'h0000_0010, 32767, -8388608));
      send_sample(make_sample(FUNC_CLEAR, 1, 32'hFFFF_FFFF, -1, -1));
      send_sample(make_sample(FUNC_SAMPLE, 1, 5, 2, -3));
      send_sample(make_sample(FUNC_SAMPLE, 1, 9, -3, 2));

      set_gap('0);
      drain();
      csr_write(SPARE_ADDR, $urandom);
      csr_check_gap();
      send_sample(make_sample(FUNC_SAMPLE, 1, 20, 4, 4));
      send_sample(make_sample(FUNC_SAMPLE, 1, 21, 4, 4));
      send_sample(make_sample(FUNC_SAMPLE, 1, 21, 4, 4));

      gap_plan = {32'hFFFF_FFFF, 32'd1, 32'd0, 32'd100, 32'($urandom_range(2, 20000)),
                  GAP_RESET, $urandom};
      foreach (gap_plan[i]) begin
         set_gap(gap_plan[i]);
         now = $urandom;
         repeat (50) send_sample(random_sample(now, gap_plan[i]));
      end

      // Long intervals at full-scale power drive the energy totals into saturation.
      set_gap(32'hFFFF_FFFF);
      send_sample(make_sample(FUNC_CLEAR, 0, 0, 0, 0));
      now = $urandom;
      for (int k = 0; k < 271; k++) begin
         if (k == 135) begin
            send_sample(make_sample(FUNC_CLEAR, 0, now, 0, 0));
         end else begin
            now = now + 32'hFFFF_FF00 + $urandom_range(0, 255);
            send_sample(make_sample(FUNC_SAMPLE, 1, now, $urandom,
                                    (k < 135) ? 24'sd8388607 - $urandom_range(0, 3)
                                              : -24'sd8388608 + $urandom_range(0, 3)));
         end
      end
      repeat (40) send_sample(random_sample(now, 32'hFFFF_FFFF));

      drain();
      repeat (200) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("coulomb_energy_integrator test passed");
      end else begin
         $display("coulomb_energy_integrator test failed");
      end
      $finish;
   end

endmodule

// ===== coulomb_energy_integrator.f =====
sv/cei_pkg.sv
sv/cei_div.sv
sv/coulomb_energy_integrator.sv
sv/cei_checker.sv
tb/tb_coulomb_energy_integrator.sv
